>>> rtl/b62f_pkg.sv
package b62f_pkg;

  localparam int unsigned NumDigits = 11;
  localparam int unsigned DigitW    = 6;
  localparam int unsigned NumCells  = NumDigits * DigitW;
  localparam int unsigned DigitsW   = NumDigits * DigitW;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned WeightW   = ValueW + 1;
  localparam int unsigned CountW    = 4;
  localparam int unsigned PosW      = 4;
  localparam int unsigned BitPosW   = 3;
  localparam int unsigned CharW     = 7;
  localparam int unsigned Radix     = 62;

  // word travelling down the cell chain
  typedef struct packed {
    logic               valid;
    logic [ValueW-1:0]  rem;
    logic [DigitW-1:0]  cur;
    logic [DigitsW-1:0] digits;
    logic [CountW-1:0]  count;
  } cell_data_t;

  // fixed per-cell setup
  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [PosW-1:0]    digit_pos;
    logic [BitPosW-1:0] bit_pos;
  } cell_cfg_t;

  // weight = 2^bit_pos * 62^digit_pos, elaboration only
  function automatic cell_cfg_t cell_cfg(int unsigned digit_pos, int unsigned bit_pos);
    cell_cfg_t          c;
    logic [WeightW-1:0] w;
    w = WeightW'(1) << bit_pos;
    for (int unsigned i = 0; i < digit_pos; i++) begin
      w = w * WeightW'(Radix);
    end
    c.weight    = w;
    c.digit_pos = PosW'(digit_pos);
    c.bit_pos   = BitPosW'(bit_pos);
    return c;
  endfunction

  // 0-9, a-z, A-Z
  function automatic logic [CharW-1:0] digit_char(logic [DigitW-1:0] d);
    logic [CharW-1:0] dw;
    logic [CharW-1:0] ch;
    dw = CharW'(d);
    if (dw < CharW'(10)) begin
      ch = CharW'(8'h30) + dw;
    end else if (dw < CharW'(36)) begin
      ch = CharW'(8'h61) + dw - CharW'(10);
    end else begin
      ch = CharW'(8'h41) + dw - CharW'(36);
    end
    return ch;
  endfunction

endpackage

>>> rtl/b62f_cell.sv
module b62f_cell import b62f_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_cfg_t  cfg_i,
  input  cell_data_t data_i,
  output cell_data_t data_o
);

  cell_data_t        data_d, data_q;
  logic              take;
  logic [DigitW-1:0] digit;

  always_comb begin
    data_d = data_i;
    take   = {1'b0, data_i.rem} >= cfg_i.weight;
    if (take) begin
      data_d.rem = data_i.rem - cfg_i.weight[ValueW-1:0];
    end
    data_d.cur[cfg_i.bit_pos] = take;
    digit = data_d.cur;
    // digit done: push it into the digit vector, note first nonzero digit
    if (cfg_i.bit_pos == '0) begin
      data_d.digits = {data_i.digits[DigitsW-DigitW-1:0], digit};
      data_d.cur    = '0;
      if (data_i.count == '0 && digit != '0) begin
        data_d.count = CountW'(cfg_i.digit_pos + PosW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

>>> rtl/b62f_serializer.sv
module b62f_serializer import b62f_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_data_t       data_i,
  output logic             valid_o,
  output logic [CharW-1:0] character_o,
  output logic [CountW-1:0] digit_count_o,
  output logic             last_o
);

  logic              active_d, active_q;
  logic [PosW-1:0]   ptr_d, ptr_q;
  logic [CountW-1:0] count_d, count_q;
  logic [DigitW-1:0] digit_q [NumDigits];
  logic              at_last;

  assign at_last = ptr_q == '0;

  always_comb begin
    active_d = active_q;
    ptr_d    = ptr_q;
    count_d  = count_q;
    if (data_i.valid) begin
      active_d = 1'b1;
      count_d  = (data_i.count == '0) ? CountW'(1) : data_i.count;
      ptr_d    = PosW'(count_d - CountW'(1));
    end else if (active_q) begin
      active_d = !at_last;
      ptr_d    = ptr_q - PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    count_q <= count_d;
    if (data_i.valid) begin
      for (int unsigned i = 0; i < NumDigits; i++) begin
        digit_q[i] <= data_i.digits[i*DigitW +: DigitW];
      end
    end
  end

  assign valid_o       = active_q;
  assign character_o   = digit_char(digit_q[ptr_q]);
  assign digit_count_o = count_q;
  assign last_o        = at_last;

endmodule

>>> rtl/base62_number_formatter.sv
// base62_number_formatter
// Turns one unsigned 64-bit word into base-62 text (0-9, a-z, A-Z), most
// significant character first, leading zeros dropped; zero gives "0".
// Input: a word is taken at a rising edge with start high and busy low.
// busy rises right after each accept and stays high while the spacing
// counter runs down, so the serializer can drain a run of at most 11
// characters before the next word is taken.
// Output: each character shows for one cycle with valid_o high, together
// with digit_count_o (same on every character of a run) and last_o on the
// least significant character. Characters of one run come in consecutive
// cycles. The receiver cannot stall the block.
// The first character reaches the ports through one register per cell
// (66, the first loading at the accepting edge) and then the serializer
// register. A run holds digit_count_o characters.
// The conversion is a chain of 66 compare-subtract cells, six per digit,
// each trying one bit of one digit against 2^b * 62^k. Several words may
// be in flight along the chain at once.
// Reset clears the chain, the serializer's active flag and the accept
// spacing counter.
module base62_number_formatter import b62f_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ValueW-1:0] value_i,
  output logic              valid_o,
  output logic [CharW-1:0]  character_o,
  output logic [CountW-1:0] digit_count_o,
  output logic              last_o
);

  localparam logic [CountW-1:0] GapCycles = CountW'(NumDigits - 1);

  logic              accept;
  logic [CountW-1:0] gap_d, gap_q;
  cell_data_t        chain [NumCells+1];

  // spacing counter: holds busy high after each accepted word
  assign accept = start && !busy;
  assign busy   = gap_q != '0;

  always_comb begin
    gap_d = gap_q;
    if (accept) begin
      gap_d = GapCycles;
    end else if (gap_q != '0) begin
      gap_d = gap_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else begin
      gap_q <= gap_d;
    end
  end

  // head of the chain
  always_comb begin
    chain[0].valid  = accept;
    chain[0].rem    = value_i;
    chain[0].cur    = '0;
    chain[0].digits = '0;
    chain[0].count  = '0;
  end

  // cells ordered top digit first, top bit first within a digit
  for (genvar gd = 0; gd < NumDigits; gd++) begin : g_digit
    for (genvar gb = 0; gb < DigitW; gb++) begin : g_bit
      localparam int unsigned S = gd * DigitW + gb;
      localparam cell_cfg_t   Cfg = cell_cfg(NumDigits - 1 - gd, DigitW - 1 - gb);

      b62f_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cfg_i  (Cfg),
        .data_i (chain[S]),
        .data_o (chain[S+1])
      );
    end
  end

  b62f_serializer u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_i        (chain[NumCells]),
    .valid_o       (valid_o),
    .character_o   (character_o),
    .digit_count_o (digit_count_o),
    .last_o        (last_o)
  );

`ifndef SYNTH
  // accept must hold off the next word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after accept");

  // a run has no gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> (valid_o && $stable(digit_count_o)))
    else $error("character run broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (digit_count_o != '0 && digit_count_o <= CountW'(NumDigits)))
    else $error("digit count out of range");
`endif

endmodule
